// ===== rtl/core/cc20_pkg.sv =====
// Package of shared types and constants for the ChaCha20 stream XOR block.
`default_nettype none

package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
    localparam int RND_W         = $clog2(HALF_ROUNDS);

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNTER = 3'd6;

    localparam logic [1:0] STEP_AB16 = 2'd0;
    localparam logic [1:0] STEP_CD12 = 2'd1;
    localparam logic [1:0] STEP_AB8  = 2'd2;
    localparam logic [1:0] STEP_CD7  = 2'd3;

    typedef logic [15:0][31:0] blk_t;

    typedef struct packed {
        logic       capture;
        logic       load_init;
        logic       round_en;
        logic [1:0] step;
        logic       diag;
        logic       feed;
        logic       emit_direct;
        logic       emit_held;
    } dp_cmd_t;

    typedef struct packed {
        logic need_block;
        logic slot_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cc20_ctrl.sv =====
// Controller state machine that sequences block generation and byte transfers.
`default_nettype none

module cc20_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cc20_pkg::dp_sts_t sts,
    output cc20_pkg::dp_cmd_t     cmd
);
    import cc20_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FEED  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             accept;

    assign in_ready = (state_reg == S_IDLE) && sts.slot_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.diag   = rnd_reg[0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (sts.need_block)
                    begin
                        cmd.load_init = 1'b1;
                        step_next     = STEP_AB16;
                        rnd_next      = '0;
                        state_next    = S_ROUND;
                    end
                    else
                    begin
                        cmd.emit_direct = 1'b1;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == STEP_CD7)
                begin
                    if (rnd_reg == RND_W'(HALF_ROUNDS - 1))
                    begin
                        state_next = S_FEED;
                    end
                    else
                    begin
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                end
            end
            S_FEED:
            begin
                cmd.feed   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_AB16;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rnd_reg   <= rnd_next;
        end
    end

    a_round_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FEED) |-> ($past(rnd_reg) == RND_W'(HALF_ROUNDS - 1)
            && $past(step_reg) == STEP_CD7))
        else $error("feed-forward entered before all rounds ran");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_direct && cmd.emit_held))
        else $error("two result sources selected at once");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("input offered a transfer while a block was being computed");

endmodule

`default_nettype wire

// ===== rtl/core/cc20_dp.sv =====
// Datapath with configuration registers, round state, counters and output register.
`default_nettype none

module cc20_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                     cfg_data,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            last_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           out_byte,
    output logic                                 out_last,
    input  wire cc20_pkg::dp_cmd_t               cmd,
    output cc20_pkg::dp_sts_t                    sts
);
    import cc20_pkg::*;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg;
    logic [31:0] nonce_hi_reg, start_ctr_reg;
    logic [31:0] blk_ctr_reg, blk_ctr_next;
    logic [5:0]  pos_reg;
    logic        in_msg_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [7:0]  hold_byte_reg;
    logic        hold_last_reg;
    blk_t        w_reg, w_next, init_vec;
    logic [31:0] ctr_use, ctr_sel, word_sel;
    logic [7:0]  ks_byte, src_byte;
    logic        src_last, emit;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    assign ctr_use = in_msg_reg ? blk_ctr_reg : start_ctr_reg;
    assign ctr_sel = cmd.load_init ? ctr_use : blk_ctr_reg;

    always_comb
    begin
        init_vec[0]  = SIGMA_0;
        init_vec[1]  = SIGMA_1;
        init_vec[2]  = SIGMA_2;
        init_vec[3]  = SIGMA_3;
        init_vec[4]  = key0_reg[31:0];
        init_vec[5]  = key0_reg[63:32];
        init_vec[6]  = key1_reg[31:0];
        init_vec[7]  = key1_reg[63:32];
        init_vec[8]  = key2_reg[31:0];
        init_vec[9]  = key2_reg[63:32];
        init_vec[10] = key3_reg[31:0];
        init_vec[11] = key3_reg[63:32];
        init_vec[12] = ctr_sel;
        init_vec[13] = nonce_lo_reg[31:0];
        init_vec[14] = nonce_lo_reg[63:32];
        init_vec[15] = nonce_hi_reg;
    end

    always_comb
    begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] sum;
        ia     = '0;
        ib     = '0;
        ic     = '0;
        id     = '0;
        sum    = '0;
        w_next = w_reg;
        if (cmd.load_init)
        begin
            w_next = init_vec;
        end
        else if (cmd.round_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                ia = {2'b00, 2'(l)};
                ib = {2'b01, (2'(l) + {1'b0, cmd.diag})};
                ic = {2'b10, (2'(l) + {cmd.diag, 1'b0})};
                id = {2'b11, (2'(l) + {cmd.diag, cmd.diag})};
                case (cmd.step)
                    STEP_AB16:
                    begin
                        sum        = w_reg[ia] + w_reg[ib];
                        w_next[ia] = sum;
                        w_next[id] = rotl(w_reg[id] ^ sum, 16);
                    end
                    STEP_CD12:
                    begin
                        sum        = w_reg[ic] + w_reg[id];
                        w_next[ic] = sum;
                        w_next[ib] = rotl(w_reg[ib] ^ sum, 12);
                    end
                    STEP_AB8:
                    begin
                        sum        = w_reg[ia] + w_reg[ib];
                        w_next[ia] = sum;
                        w_next[id] = rotl(w_reg[id] ^ sum, 8);
                    end
                    default:
                    begin
                        sum        = w_reg[ic] + w_reg[id];
                        w_next[ic] = sum;
                        w_next[ib] = rotl(w_reg[ib] ^ sum, 7);
                    end
                endcase
            end
        end
        else if (cmd.feed)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = w_reg[i] + init_vec[i];
            end
        end
    end

    always_comb
    begin
        blk_ctr_next = blk_ctr_reg;
        if (cmd.load_init)
        begin
            blk_ctr_next = ctr_use;
        end
        else if (cmd.feed)
        begin
            blk_ctr_next = blk_ctr_reg + 32'd1;
        end
    end

    assign word_sel = w_reg[pos_reg[5:2]];
    assign ks_byte  = 8'(word_sel >> {pos_reg[1:0], 3'b000});
    assign src_byte = cmd.emit_held ? hold_byte_reg : in_byte;
    assign src_last = cmd.emit_held ? hold_last_reg : last_byte;
    assign emit     = cmd.emit_direct || cmd.emit_held;

    assign sts.need_block = (pos_reg == 6'd0);
    assign sts.slot_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            nonce_lo_reg  <= '0;
            nonce_hi_reg  <= '0;
            start_ctr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_PART_0:    key0_reg      <= cfg_data;
                REG_KEY_PART_1:    key1_reg      <= cfg_data;
                REG_KEY_PART_2:    key2_reg      <= cfg_data;
                REG_KEY_PART_3:    key3_reg      <= cfg_data;
                REG_NONCE_LOW:     nonce_lo_reg  <= cfg_data;
                REG_NONCE_HIGH:    nonce_hi_reg  <= cfg_data[31:0];
                REG_START_COUNTER: start_ctr_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_ctr_reg   <= '0;
            pos_reg       <= '0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_ctr_reg <= blk_ctr_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= src_last ? 6'd0 : pos_reg + 6'd1;
                in_msg_reg    <= !src_last;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.capture)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= last_byte;
        end
        if (emit)
        begin
            out_byte_reg <= src_byte ^ ks_byte;
            out_last_reg <= src_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_direct || cmd.emit_held) |-> (!out_valid_reg || out_ready))
        else $error("result written over one that was not taken");

    a_load_at_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_init |-> (pos_reg == 6'd0))
        else $error("block generated in mid-block");

    a_counter_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.feed |=> (blk_ctr_reg == $past(blk_ctr_reg) + 32'd1))
        else $error("block counter did not advance after a block");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_byte_reg)
            && $stable(out_last_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/core/chacha20_stream_xor.sv =====
// Top level of the ChaCha20 stream XOR block: controller plus datapath.
//
// Usage: key, nonce and start counter are written through the cfg channel
// (cfg_index selects the register, cfg_data carries the value); writes are
// always taken and must happen only while no byte is in flight.
// Bytes enter on the in channel (in_byte, last_byte) and each transfer gives
// exactly one result on the out channel (out_byte, out_last), in order.
// At the first byte of each 64-byte keystream block the block is computed
// with one add-xor-rotate step of four quarter rounds per cycle, then a
// feed-forward step, and that byte's result is written once the result
// slot is free. Every other byte is XORed at transfer and its result is
// valid the next cycle, one byte per cycle while the receiver takes results.
// A byte with last_byte set ends the message; the next byte starts a new one
// with the block counter reloaded from start_counter.
// Reset clears the configuration registers, position, counter and out_valid.
// A stalled receiver holds the result register; the block takes one more
// byte only once that slot is free or being taken in the same cycle.
`default_nettype none

module chacha20_stream_xor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     in_byte,
    input  wire logic                           last_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_byte,
    output logic                                out_last
);
    import cc20_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    cc20_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cc20_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
